>>> rtl/fpm_pkg.sv
// floored positive modulo: shared widths, payload structs and the
// controller-to-datapath command and status types; no dependencies
`default_nettype none

package fpm_pkg;

  // dividend width; the modulus and the remainder are one bit narrower
  localparam int DATA_WIDTH = 48;
  localparam int MOD_WIDTH  = DATA_WIDTH - 1;
  // step counter covers one step per dividend bit
  localparam int CNT_W      = $clog2(DATA_WIDTH);

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic        [MOD_WIDTH-1:0]  modulus;
    logic                         modulus_infinite;
  } in_word_t;

  typedef struct packed {
    logic [MOD_WIDTH-1:0] remainder;
    logic                 zero_modulus_error;
  } out_word_t;

  // commands from the controller
  typedef struct packed {
    logic load;  // capture magnitude, modulus and flags
    logic step;  // one restoring shift-subtract step
    logic fix;   // wrap a negative dividend's remainder
    logic emit;  // move the remainder into the output register
  } fpm_cmd_t;

  // status back to the controller
  typedef struct packed {
    logic trivial;  // infinite or zero modulus, no iteration needed
  } fpm_stat_t;

endpackage

`default_nettype wire

>>> rtl/fpm_datapath.sv
// floored positive modulo datapath: magnitude, shift-subtract remainder,
// sign fix-up and output register; depends on fpm_pkg
`default_nettype none

module fpm_datapath (
  input  wire logic              clk,
  input  wire fpm_pkg::in_word_t in_data,
  input  wire fpm_pkg::fpm_cmd_t cmd,
  output fpm_pkg::fpm_stat_t     stat,
  output fpm_pkg::out_word_t     out_data
);

  localparam int W = fpm_pkg::DATA_WIDTH;
  localparam int M = fpm_pkg::MOD_WIDTH;

  logic [W-1:0] quo_r, quo_nxt;   // dividend bits still to shift in
  logic [W-1:0] rem_r, rem_nxt;   // partial remainder, always below modulus
  logic [M-1:0] mod_r, mod_nxt;
  logic         neg_r, neg_nxt;
  logic         err_r, err_nxt;
  fpm_pkg::out_word_t out_r, out_nxt;

  logic [W-1:0] mag;
  logic [W-1:0] rem_shift;
  logic [W:0]   rem_diff;
  logic [M-1:0] rem_wrap;
  logic         mod_zero;

  // input classification
  assign mod_zero     = (in_data.modulus == '0);
  assign stat.trivial = in_data.modulus_infinite | mod_zero;

  // magnitude of the dividend, exact for the most negative value
  assign mag = in_data.value[W-1] ? (~in_data.value + W'(1)) : in_data.value;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_shift = {rem_r[W-2:0], quo_r[W-1]};
  assign rem_diff  = {1'b0, rem_shift} - {2'b00, mod_r};

  // negative dividend with nonzero remainder wraps to modulus minus remainder
  assign rem_wrap = mod_r - rem_r[M-1:0];

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    mod_nxt = mod_r;
    neg_nxt = neg_r;
    err_nxt = err_r;
    out_nxt = out_r;
    if (cmd.load) begin
      quo_nxt = mag;
      rem_nxt = '0;
      mod_nxt = in_data.modulus;
      neg_nxt = in_data.value[W-1];
      err_nxt = ~in_data.modulus_infinite & mod_zero;
    end
    if (cmd.step) begin
      quo_nxt = {quo_r[W-2:0], 1'b0};
      rem_nxt = rem_diff[W] ? rem_shift : rem_diff[W-1:0];
    end
    if (cmd.fix && neg_r && (rem_r != '0)) begin
      rem_nxt = {1'b0, rem_wrap};
    end
    if (cmd.emit) begin
      out_nxt.remainder          = rem_r[M-1:0];
      out_nxt.zero_modulus_error = err_r;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    mod_r <= mod_nxt;
    neg_r <= neg_nxt;
    err_r <= err_nxt;
    out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

>>> rtl/fpm_controller.sv
// floored positive modulo controller: sequences load, one step per dividend
// bit, fix-up and output hand-off; depends on fpm_pkg
`default_nettype none

module fpm_controller (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire fpm_pkg::fpm_stat_t stat,
  output fpm_pkg::fpm_cmd_t       cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FIX,
    ST_DONE
  } state_t;

  state_t                    state_r, state_nxt;
  logic [fpm_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic                      in_fire;
  logic                      emit;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid & in_ready;
  // hand the result over once the output register is free or being drained
  assign emit     = (state_r == ST_DONE) & (~out_valid_r | out_ready);

  // commands to the datapath
  always_comb begin
    cmd      = '0;
    cmd.load = in_fire;
    cmd.step = (state_r == ST_RUN);
    cmd.fix  = (state_r == ST_FIX);
    cmd.emit = emit;
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cnt_nxt   = fpm_pkg::CNT_W'(fpm_pkg::DATA_WIDTH - 1);
          state_nxt = stat.trivial ? ST_DONE : ST_RUN;
        end
      end
      ST_RUN: begin
        cnt_nxt = cnt_r - fpm_pkg::CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = ST_FIX;
        end
      end
      ST_FIX: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (emit) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

>>> rtl/floored_positive_modulo_core.sv
// sequence: load, one step per dividend bit in the shared shift-subtract
// unit, sign fix-up, hand-off; an infinite or zero modulus skips the steps
// and the fix-up. a word is accepted only while idle, so the 48 sequential
// subtract steps of one word finish before the next word starts. the output
// register lets the next word in while a result waits. synchronous active-low
// reset clears the controller and the output valid; the datapath is not reset.
// depends on fpm_pkg, fpm_controller, fpm_datapath
`default_nettype none

module floored_positive_modulo_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire fpm_pkg::in_word_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output fpm_pkg::out_word_t      out_data
);

  fpm_pkg::fpm_cmd_t  cmd;
  fpm_pkg::fpm_stat_t stat;

  // sequencing
  fpm_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic
  fpm_datapath u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

  // error words always carry a zero remainder
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.zero_modulus_error) |-> (out_data.remainder == '0))
    else $error("error word with nonzero remainder");

  // busy after accepting a word
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after accept");

  // infinite or zero modulus bypasses the iteration
  a_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !out_valid &&
     (in_data.modulus_infinite || (in_data.modulus == '0))) |-> ##2 out_valid)
    else $error("trivial modulus result late");

  // steps only while a word is in flight
  a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !in_ready)
    else $error("step while idle");

endmodule

`default_nettype wire

>>> test/tb_top.sv
// testbench for floored_positive_modulo_core: directed table plus random words,
// every result checked against a typed table value or an in-bench floored remainder predictor
// depends on fpm_pkg and the floored_positive_modulo_core rtl
`timescale 1ns / 1ps

module tb_top;

  localparam int DATA_WIDTH    = fpm_pkg::DATA_WIDTH;
  localparam int MOD_WIDTH     = fpm_pkg::MOD_WIDTH;
  localparam int CLK_PERIOD    = 12;
  localparam int RESET_CYCLES  = 8;
  localparam int RANDOM_WORDS  = 1930;
  localparam int CYCLE_LIMIT   = 1_000_000;
  // drain allowance, with slack beyond the longest path through the block
  localparam int DRAIN_CYCLES  = 80;
  localparam int HOLD_CYCLES   = 600;
  localparam int IDLE_PERCENT  = 11;

  typedef struct {
    fpm_pkg::in_word_t  word;
    bit                 typed;
    fpm_pkg::out_word_t res;
  } table_row_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  fpm_pkg::in_word_t  in_data;
  logic               out_valid;
  logic               out_ready;
  fpm_pkg::out_word_t out_data;

  fpm_pkg::out_word_t remainder_q[$];
  table_row_t         directed_rows[$];
  int                 failures;
  int                 results_seen;
  int                 words_sent;
  int                 zero_mod_sent;
  int                 infinite_sent;
  int                 cycles;

  floored_positive_modulo_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // floored remainder in [0, modulus), sign wrapped for negative dividends
  function automatic fpm_pkg::out_word_t floored_mod(input fpm_pkg::in_word_t w);
    fpm_pkg::out_word_t    res;
    logic [DATA_WIDTH-1:0] mag;
    logic [DATA_WIDTH-1:0] rem;
    logic [DATA_WIDTH-1:0] modulus_wide;
    logic                  neg;
    res = '0;
    if (w.modulus_infinite) begin
      return res;
    end
    if (w.modulus == '0) begin
      res.zero_modulus_error = 1'b1;
      return res;
    end
    neg          = w.value[DATA_WIDTH-1];
    modulus_wide = {1'b0, w.modulus};
    mag          = w.value;
    // two's complement negate, exact for the most negative value too
    if (neg) begin
      mag = -mag;
    end
    rem = mag % modulus_wide;
    if (neg && rem != '0) begin
      rem = modulus_wide - rem;
    end
    res.remainder = rem[MOD_WIDTH-1:0];
    return res;
  endfunction

  function automatic void add_row(input logic [DATA_WIDTH-1:0] v,
                                  input logic [MOD_WIDTH-1:0] m, input logic inf,
                                  input bit typed, input logic [MOD_WIDTH-1:0] rem,
                                  input logic err);
    table_row_t row;
    row.word.value              = v;
    row.word.modulus            = m;
    row.word.modulus_infinite   = inf;
    row.typed                   = typed;
    row.res.remainder           = rem;
    row.res.zero_modulus_error  = err;
    directed_rows.push_back(row);
  endfunction

  // random word: full range, shifted magnitudes, exact multiples, extreme
  // dividend values, and the zero and infinite modulus cases
  function automatic fpm_pkg::in_word_t random_word();
    fpm_pkg::in_word_t w;
    logic [63:0]       raw_v;
    logic [63:0]       raw_m;
    longint            multiple;
    int                sel;
    raw_v = {$urandom, $urandom};
    raw_m = {$urandom, $urandom};
    sel   = $urandom_range(0, 99);
    w.value            = $signed(raw_v[DATA_WIDTH-1:0]) >>> $urandom_range(0, DATA_WIDTH-1);
    w.modulus          = raw_m[MOD_WIDTH-1:0] >> $urandom_range(0, MOD_WIDTH-1);
    w.modulus_infinite = 1'b0;
    if (sel < 5) begin
      w.modulus = '0;
    end else if (sel < 11) begin
      w.modulus_infinite = 1'b1;
      if ($urandom_range(0, 3) == 0) w.modulus = '0;
    end else if (sel < 18) begin
      // exact multiple of a small modulus, either sign
      w.modulus = MOD_WIDTH'(raw_m[19:0]);
      if (w.modulus == '0) w.modulus = MOD_WIDTH'(1);
      multiple  = longint'(w.modulus) * longint'($signed(raw_v[25:0]));
      w.value   = multiple[DATA_WIDTH-1:0];
    end else if (sel < 22) begin
      case ($urandom_range(0, 3))
        0: w.value = {1'b1, {(DATA_WIDTH-1){1'b0}}};
        1: w.value = {1'b0, {(DATA_WIDTH-1){1'b1}}};
        2: w.value = '1;
        default: w.value = '0;
      endcase
    end else if (sel < 30) begin
      w.value = raw_v[DATA_WIDTH-1:0];
    end
    return w;
  endfunction

  // offer one word, hold it until accepted, then record what it must give
  task automatic send_word(input fpm_pkg::in_word_t w, input bit typed,
                           input fpm_pkg::out_word_t typed_res, input bit no_gaps);
    int gap;
    gap = 0;
    if (!no_gaps) begin
      while ($urandom_range(0, 99) < IDLE_PERCENT) gap++;
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    remainder_q.push_back(typed ? typed_res : floored_mod(w));
    words_sent++;
    if (w.modulus_infinite) infinite_sent++;
    else if (w.modulus == '0) zero_mod_sent++;
  endtask

  // result checker
  always @(posedge clk) begin
    fpm_pkg::out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (remainder_q.size() == 0) begin
        $error("unexpected result word: remainder %h zero_modulus_error %b",
               out_data.remainder, out_data.zero_modulus_error);
        failures++;
      end else begin
        want = remainder_q.pop_front();
        if (out_data.remainder !== want.remainder) begin
          $error("remainder: expected %h, actual %h", want.remainder, out_data.remainder);
          failures++;
        end
        if (out_data.zero_modulus_error !== want.zero_modulus_error) begin
          $error("zero_modulus_error: expected %b, actual %b",
                 want.zero_modulus_error, out_data.zero_modulus_error);
          failures++;
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off, one stretch always ready
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    forever begin
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && results_seen >= 300) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (results_seen >= 700 && results_seen < 1100) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
      @(posedge clk);
    end
  end

  // run limit
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, remainder_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  // main sequence
  initial begin
    fpm_pkg::out_word_t none;
    none          = '0;
    failures      = 0;
    results_seen  = 0;
    words_sent    = 0;
    zero_mod_sent = 0;
    infinite_sent = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero dividend, infinite and zero modulus
    add_row(48'h0000_0000_0000, 47'h0, 1'b0, 1'b0, 47'h0, 1'b0);
    add_row(48'h0000_0000_0000, 47'h1, 1'b0, 1'b1, 47'h0, 1'b0);
    add_row(48'h1234_5678_9ABC, 47'h0, 1'b1, 1'b1, 47'h0, 1'b0);
    add_row(48'h8000_0000_0000, 47'h7FFF_FFFF_FFFF, 1'b1, 1'b1, 47'h0, 1'b0);
    add_row(48'h0000_0000_0005, 47'h0, 1'b0, 1'b1, 47'h0, 1'b1);
    add_row(48'h8000_0000_0000, 47'h0, 1'b0, 1'b1, 47'h0, 1'b1);
    add_row(48'hFFFF_FFFF_FFFF, 47'h0, 1'b0, 1'b1, 47'h0, 1'b1);
    // minus one ulp wraps to modulus minus one ulp
    add_row(48'hFFFF_FFFF_FFFF, 47'h1_0000, 1'b0, 1'b1, 47'h0_FFFF, 1'b0);
    add_row(48'hFFFF_FFFF_FFFF, 47'h7FFF_FFFF_FFFF, 1'b0, 1'b1, 47'h7FFF_FFFF_FFFE, 1'b0);
    // extremes of dividend and modulus
    add_row(48'h7FFF_FFFF_FFFF, 47'h7FFF_FFFF_FFFF, 1'b0, 1'b1, 47'h0, 1'b0);
    add_row(48'h8000_0000_0000, 47'h7FFF_FFFF_FFFF, 1'b0, 1'b0, 47'h0, 1'b0);
    add_row(48'h8000_0000_0000, 47'h1, 1'b0, 1'b1, 47'h0, 1'b0);
    add_row(48'h8000_0000_0000, 47'h1_0000, 1'b0, 1'b1, 47'h0, 1'b0);
    add_row(48'h8000_0000_0000, 47'h3, 1'b0, 1'b0, 47'h0, 1'b0);
    add_row(48'h7FFF_FFFF_FFFF, 47'h3, 1'b0, 1'b0, 47'h0, 1'b0);
    add_row(48'h7FFF_FFFF_FFFF, 47'h1, 1'b0, 1'b1, 47'h0, 1'b0);
    // negative exact multiple: -3 * 1.5
    add_row(48'hFFFF_FFFB_8000, 47'h1_8000, 1'b0, 1'b1, 47'h0, 1'b0);
    // small plain cases
    add_row(48'h0000_0005_0003, 47'h1_0000, 1'b0, 1'b1, 47'h3, 1'b0);
    add_row(48'h0000_0000_0064, 47'd1000, 1'b0, 1'b1, 47'd100, 1'b0);
    add_row(48'hFFFF_FFFF_FF9C, 47'd1000, 1'b0, 1'b1, 47'd900, 1'b0);
    add_row(48'h0000_0001_0000, 47'h7FFF_FFFF_FFFF, 1'b0, 1'b1, 47'h1_0000, 1'b0);
    // alternating bit patterns
    add_row(48'h5555_5555_5555, 47'h2AAA_AAAA_AAAA, 1'b0, 1'b0, 47'h0, 1'b0);
    add_row(48'hAAAA_AAAA_AAAA, 47'h5555_5555_5555, 1'b0, 1'b0, 47'h0, 1'b0);
    add_row(48'h1234_5678_9ABC, 47'h0_0001_8000, 1'b0, 1'b0, 47'h0, 1'b0);

    foreach (directed_rows[i]) begin
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].res, 1'b0);
    end

    // random words, with one run of back-to-back words and one full drain
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 1200) begin
        in_valid <= 1'b0;
        do @(posedge clk); while (remainder_q.size() != 0);
      end
      send_word(random_word(), 1'b0, none, (n >= 400 && n < 800));
    end
    in_valid <= 1'b0;

    while (remainder_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d words (%0d directed), %0d zero modulus, %0d infinite modulus",
             words_sent, directed_rows.size(), zero_mod_sent, infinite_sent);
    $display("checked %0d result words in %0d cycles, %0d mismatches",
             results_seen, cycles, failures);
    if (failures == 0 && remainder_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
